// ===== src/fvr_pkg.sv =====
package fvr_pkg;

	// index range and derived widths
	localparam int INDEX_BITS = 24;
	localparam int MAG_W      = INDEX_BITS + 1;
	localparam int ACC_W      = MAG_W + 4;
	localparam int OUT_W      = 24;
	localparam int CALC_W     = (MAG_W > OUT_W + 1) ? MAG_W : OUT_W + 1;
	localparam int FIELDS     = 3;

	localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(1) << INDEX_BITS;
	localparam logic [OUT_W-1:0] OUT_MASK  = '1;

	// token queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// register file
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_VERTEX_COUNT  = 2'd0;
	localparam logic [1:0] REG_TEXTURE_COUNT = 2'd1;
	localparam logic [1:0] REG_NORMAL_COUNT  = 2'd2;

	// field numbers
	localparam logic [1:0] FLD_VERTEX = 2'd0;
	localparam logic [1:0] FLD_IGNORE = 2'd3;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// per-field number scan phase
	typedef enum logic [2:0] {
		PH_SKIP = 3'b001,
		PH_NUM  = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
	} chr_t;

	typedef struct packed {
		logic [OUT_W-1:0] vertex_index;
		logic [OUT_W-1:0] texture_index;
		logic [OUT_W-1:0] normal_index;
		logic             texture_present;
		logic             normal_present;
		logic             out_of_range;
		logic             last_of_line;
	} ref_t;

	// closed token handed from front to back
	typedef struct packed {
		logic [FIELDS-1:0][MAG_W-1:0] mag;
		logic [FIELDS-1:0]            neg;
		logic                         sat;
		logic                         last;
	} tok_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

// ===== src/face_vertex_ref_parser.sv =====
// Face vertex reference parser.
// Channel chr (chr_valid/chr_ready/chr_data) takes one character of a face
// line per beat, with line_end marking the last character. A space or the
// line end closes a token; slashes split it into vertex/texture/normal fields.
// Channel ref (ref_valid/ref_ready/ref_data) gives one beat per token whose
// vertex field is nonzero: zero-based indices, present bits, range flag and
// whether the token ended the line.
// Throughput: one character per cycle while the token queue is not full; the
// character scanner does one multiply-by-ten accumulate per beat. A result is
// written to the queue by the beat that closed its token, then resolved by the
// subtract into the output register once that register is free.
// A four-entry token queue sits between scanner and resolver, so while ref is
// stalled characters are still taken until the queue fills; chr_ready then
// drops. The APB registers hold the vertex, texture and normal counts used for
// negative references; write them only while the block is idle.
// Reset clears the counts, the partial token, the queue and the output valid.
module face_vertex_ref_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          chr_valid,
	output logic                          chr_ready,
	input  fvr_pkg::chr_t                 chr_data,
	output logic                          ref_valid,
	input  logic                          ref_ready,
	output fvr_pkg::ref_t                 ref_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fvr_pkg::PADDR_W-1:0]   paddr,
	input  logic [fvr_pkg::PDATA_W-1:0]   pwdata,
	output logic [fvr_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import fvr_pkg::*;

	logic [FIELDS-1:0][OUT_W-1:0] cnt_q;
	fifo_stat_t                   stat;
	tok_t                         push_tok;
	tok_t                         head;
	logic                         push;
	logic                         pop;
	logic [1:0]                   reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];

	// count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_VERTEX_COUNT:  cnt_q[0] <= pwdata[OUT_W-1:0];
				REG_TEXTURE_COUNT: cnt_q[1] <= pwdata[OUT_W-1:0];
				REG_NORMAL_COUNT:  cnt_q[2] <= pwdata[OUT_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_sel)
			REG_VERTEX_COUNT:  prdata = PDATA_W'(cnt_q[0]);
			REG_TEXTURE_COUNT: prdata = PDATA_W'(cnt_q[1]);
			REG_NORMAL_COUNT:  prdata = PDATA_W'(cnt_q[2]);
			default:           prdata = '0;
		endcase
	end

	fvr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.chr_data  (chr_data),
		.stat      (stat),
		.push      (push),
		.tok       (push_tok)
	);

	fvr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	fvr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.counts    (cnt_q),
		.pop       (pop),
		.ref_valid (ref_valid),
		.ref_ready (ref_ready),
		.ref_data  (ref_data)
	);

endmodule

// ===== src/fvr_front.sv =====
module fvr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 chr_valid,
	output logic                 chr_ready,
	input  fvr_pkg::chr_t        chr_data,
	input  fvr_pkg::fifo_stat_t  stat,
	output logic                 push,
	output fvr_pkg::tok_t        tok
);
	import fvr_pkg::*;

	logic [1:0]                   fn_q, fn_d;
	logic [FIELDS-1:0][MAG_W-1:0] val_q, val_d;
	logic [FIELDS-1:0]            neg_q, neg_d;
	phase_t                       ph_q [FIELDS];
	phase_t                       ph_d [FIELDS];
	logic                         sat_q, sat_d;
	logic                         close;
	logic                         accept;

	assign chr_ready = !stat.full;
	assign accept    = chr_valid && chr_ready;

	// character decode and field update
	always_comb begin
		logic             digit;
		logic             blank;
		logic             num;
		logic [ACC_W-1:0] acc;
		fn_d  = fn_q;
		val_d = val_q;
		neg_d = neg_q;
		sat_d = sat_q;
		for (int i = 0; i < FIELDS; i++) ph_d[i] = ph_q[i];
		digit = (chr_data.ch >= CH_ZERO) && (chr_data.ch <= CH_NINE);
		blank = chr_data.ch inside {CH_SPACE, [CH_TAB:CH_CR]};
		num   = 1'b0;
		acc   = '0;
		close = chr_data.line_end || (chr_data.ch == CH_SPACE);
		if (chr_data.ch == CH_SLASH) begin
			if (fn_q != FLD_IGNORE) fn_d = fn_q + 2'd1;
		end else if (chr_data.ch != CH_SPACE) begin
			for (int i = 0; i < FIELDS; i++) begin
				if (fn_q == 2'(i)) begin
					case (ph_q[i])
						PH_SKIP: begin
							if (chr_data.ch == CH_PLUS || chr_data.ch == CH_MINUS) begin
								neg_d[i] = (chr_data.ch == CH_MINUS);
								ph_d[i]  = PH_NUM;
							end else if (!blank) begin
								num = 1'b1;
							end
						end
						PH_NUM:  num = 1'b1;
						default: num = 1'b0;
					endcase
					if (num) begin
						if (!digit) begin
							ph_d[i] = PH_DONE;
						end else begin
							ph_d[i] = PH_NUM;
							// times ten plus digit
							acc = (ACC_W'(val_q[i]) << 3) + (ACC_W'(val_q[i]) << 1)
								+ ACC_W'(chr_data.ch[3:0]);
							if (acc > ACC_W'(MAG_LIMIT)) begin
								val_d[i] = MAG_LIMIT;
								sat_d    = 1'b1;
							end else begin
								val_d[i] = acc[MAG_W-1:0];
							end
						end
					end
				end
			end
		end
	end

	// hand a closed token with a vertex reference to the queue
	assign push     = accept && close && (val_d[FLD_VERTEX] != '0);
	assign tok.mag  = val_d;
	assign tok.neg  = neg_d;
	assign tok.sat  = sat_d;
	assign tok.last = chr_data.line_end;

	// token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fn_q  <= FLD_VERTEX;
			val_q <= '0;
			neg_q <= '0;
			sat_q <= 1'b0;
			for (int i = 0; i < FIELDS; i++) ph_q[i] <= PH_SKIP;
		end else if (accept) begin
			if (close) begin
				fn_q  <= FLD_VERTEX;
				val_q <= '0;
				neg_q <= '0;
				sat_q <= 1'b0;
				for (int i = 0; i < FIELDS; i++) ph_q[i] <= PH_SKIP;
			end else begin
				fn_q  <= fn_d;
				val_q <= val_d;
				neg_q <= neg_d;
				sat_q <= sat_d;
				for (int i = 0; i < FIELDS; i++) ph_q[i] <= ph_d[i];
			end
		end
	end

	// a closing beat always leaves a clean token
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && close) |=> (fn_q == FLD_VERTEX && val_q == '0 && !sat_q))
		else $error("token state not cleared after close");

endmodule

// ===== src/fvr_fifo.sv =====
module fvr_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fvr_pkg::tok_t        push_tok,
	input  logic                 pop,
	output fvr_pkg::tok_t        head,
	output fvr_pkg::fifo_stat_t  stat
);
	import fvr_pkg::*;

	tok_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign head       = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_tok;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)  rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full token queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty token queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("token queue count out of range");

endmodule

// ===== src/fvr_back.sv =====
module fvr_back (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  fvr_pkg::tok_t                                 head,
	input  fvr_pkg::fifo_stat_t                           stat,
	input  logic [fvr_pkg::FIELDS-1:0][fvr_pkg::OUT_W-1:0] counts,
	output logic                                          pop,
	output logic                                          ref_valid,
	input  logic                                          ref_ready,
	output fvr_pkg::ref_t                                 ref_data
);
	import fvr_pkg::*;

	logic                         valid_q;
	ref_t                         ref_q;
	logic [FIELDS-1:0][OUT_W-1:0] idx;
	logic                         bad;
	ref_t                         res;

	assign pop       = !stat.empty && (!valid_q || ref_ready);
	assign ref_valid = valid_q;
	assign ref_data  = ref_q;

	// absolute / relative index resolution, one subtract per field
	always_comb begin
		logic [CALC_W-1:0] m;
		logic [CALC_W-1:0] c;
		logic [CALC_W-1:0] r;
		bad = head.sat;
		for (int i = 0; i < FIELDS; i++) begin
			m = CALC_W'(head.mag[i]);
			c = CALC_W'(counts[i]);
			r = '0;
			if (m != '0) begin
				if (head.neg[i]) begin
					if (m > c) bad = 1'b1;
					else       r   = c - m;
				end else begin
					r = m - CALC_W'(1);
				end
				if (r > CALC_W'(OUT_MASK)) begin
					bad = 1'b1;
					r   = CALC_W'(OUT_MASK);
				end
			end
			idx[i] = r[OUT_W-1:0];
		end
		res.vertex_index    = idx[0];
		res.texture_index   = idx[1];
		res.normal_index    = idx[2];
		res.texture_present = (head.mag[1] != '0);
		res.normal_present  = (head.mag[2] != '0);
		res.out_of_range    = bad;
		res.last_of_line    = head.last;
	end

	// output register
	always_ff @(posedge clk) begin
		if (pop) ref_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (ref_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule
